>>> sv/pecs_pkg.sv
// Types, codes and the reset image shared by the configuration space block.
package pecs_pkg;

  typedef enum logic [2:0] {
    CMD_CFG_RD = 3'd0,
    CMD_CFG_WR = 3'd1,
    CMD_MEM_RD = 3'd2,
    CMD_MEM_WR = 3'd3,
    CMD_IO_RD  = 3'd4,
    CMD_IO_WR  = 3'd5
  } pecs_op_t;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC
  } pecs_state_t;

  typedef struct packed {
    logic init_step;
    logic accept;
    logic finish;
  } pecs_cmd_t;

  typedef struct packed {
    logic init_last;
  } pecs_sts_t;

  localparam logic [2:0] CFG_BAR0_SIZE = 3'd0;
  localparam logic [2:0] CFG_BAR_RD_EN = 3'd6;
  localparam logic [2:0] CFG_BAR_WR_EN = 3'd7;

  localparam logic [63:0] BAR_REG_FIRST = 64'h10;
  localparam logic [63:0] BAR_REG_LAST  = 64'h24;
  localparam logic [63:0] ROM_REG       = 64'h30;
  localparam logic [63:0] ALL_ONES      = '1;

  localparam int unsigned IMG_ADDR_W = 12;

  function automatic logic [7:0] image_byte(input logic [IMG_ADDR_W-1:0] a);
    logic [7:0] v;
    case (a)
      12'h006: v = 8'h10;
      12'h00A: v = 8'h80;
      12'h00B: v = 8'h11;
      12'h034: v = 8'h40;
      12'h040: v = 8'h05;
      12'h042: v = 8'h01;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

>>> sv/pecs_ctrl.sv
// Controller: reset fill sequencing, input and result handshakes.
module pecs_ctrl import pecs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output pecs_cmd_t cmd,
  input  pecs_sts_t sts
);

  pecs_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_stall      = 1'b1;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_INIT: begin
        cmd.init_step = 1'b1;
        if (sts.init_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid_r || !out_stall) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

>>> sv/pecs_datapath.sv
// Datapath: BAR registers, banked configuration store and result registers.
module pecs_datapath import pecs_pkg::*; #(
  parameter int CONFIG_BYTES = 256,
  parameter int BAR_COUNT    = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  pecs_cmd_t   cmd,
  output pecs_sts_t   sts,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic [2:0]  in_cmd,
  input  logic [63:0] in_address,
  input  logic [2:0]  in_bar_index,
  input  logic [3:0]  in_access_width,
  input  logic [63:0] in_write_data,
  output logic        out_reply_valid,
  output logic [63:0] out_reply_data,
  output logic        out_forward_read,
  output logic        out_forward_write,
  output logic [2:0]  out_forward_bar,
  output logic [63:0] out_forward_address,
  output logic [3:0]  out_forward_width,
  output logic [63:0] out_forward_data
);

  localparam int AW   = $clog2(CONFIG_BYTES);
  localparam int RW   = AW - 2;
  localparam int ROWS = (CONFIG_BYTES + 3) / 4;

  logic [31:0] bar_size_r [BAR_COUNT];
  logic [5:0]  bar_rd_en_r, bar_wr_en_r;
  logic [RW-1:0] init_row_r;

  logic [2:0]  cmd_r;
  logic [63:0] addr_r;
  logic [2:0]  bar_r;
  logic [3:0]  width_r;
  logic [63:0] data_r;
  wire  [3:0][7:0] rd_byte;

  function automatic logic [31:0] size_of(input logic [2:0] idx);
    logic [31:0] s;
    s = '0;
    for (int i = 0; i < BAR_COUNT; i++) begin
      if (idx == 3'(i)) begin
        s = bar_size_r[i];
      end
    end
    return s;
  endfunction

  function automatic logic [RW-1:0] lane_row(input logic [AW-1:0] a, input logic [1:0] b);
    return a[AW-1:2] + RW'(b < a[1:0]);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BAR_COUNT; i++) begin
        bar_size_r[i] <= '0;
      end
      bar_rd_en_r <= '0;
      bar_wr_en_r <= '0;
      init_row_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        for (int i = 0; i < BAR_COUNT; i++) begin
          if (cfg_index == CFG_BAR0_SIZE + 3'(i)) begin
            bar_size_r[i] <= cfg_wdata;
          end
        end
        if (cfg_index == CFG_BAR_RD_EN) begin
          bar_rd_en_r <= cfg_wdata[5:0];
        end
        if (cfg_index == CFG_BAR_WR_EN) begin
          bar_wr_en_r <= cfg_wdata[5:0];
        end
      end
      if (cmd.init_step) begin
        init_row_r <= init_row_r + RW'(1);
      end
    end
  end

  assign sts.init_last = (init_row_r == RW'(ROWS - 1));

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r   <= in_cmd;
      addr_r  <= in_address;
      bar_r   <= in_bar_index;
      width_r <= in_access_width;
      data_r  <= in_write_data;
    end
  end

  logic        width_ok, addr_in, fits, bar_reg_hit, bar_wr, gen_wr;
  logic [AW:0] addr_end;
  logic [2:0]  wr_bar;
  logic [31:0] wr_bar_size, bar_val;

  always_comb begin
    width_ok    = (width_r == 4'd1) || (width_r == 4'd2) || (width_r == 4'd4);
    addr_in     = (addr_r[63:AW] == '0) &&
                  ({1'b0, addr_r[AW-1:0]} < (AW+1)'(CONFIG_BYTES));
    addr_end    = (AW+1)'(addr_r[AW-1:0]) + (AW+1)'(width_r);
    fits        = addr_in && (addr_end <= (AW+1)'(CONFIG_BYTES));
    bar_reg_hit = (addr_r >= BAR_REG_FIRST) && (addr_r <= BAR_REG_LAST);
    wr_bar      = 3'(addr_r[5:2] - 4'd4);
    wr_bar_size = size_of(wr_bar);
    bar_val     = data_r[31:0] & ~(wr_bar_size - 32'd1);
    bar_wr      = (cmd_r == CMD_CFG_WR) && bar_reg_hit && (wr_bar_size != '0);
    gen_wr      = (cmd_r == CMD_CFG_WR) && !bar_reg_hit && (addr_r != ROM_REG) &&
                  width_ok && fits;
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [7:0]    mem [ROWS];
    logic [RW-1:0] rd_row, wr_row;
    logic          wr_en;
    logic [7:0]    wr_byte;
    logic [1:0]    lane;
    logic [7:0]    rd_byte_r;

    always_comb begin
      rd_row  = lane_row(in_address[AW-1:0], 2'(b));
      lane    = 2'(b) - addr_r[1:0];
      wr_en   = 1'b0;
      wr_row  = init_row_r;
      wr_byte = image_byte(IMG_ADDR_W'({init_row_r, 2'(b)}));
      if (cmd.init_step) begin
        wr_en = 1'b1;
      end else if (cmd.finish && bar_wr) begin
        wr_en   = 1'b1;
        wr_row  = RW'(addr_r[5:2]);
        wr_byte = bar_val[8*b +: 8];
      end else if (cmd.finish && gen_wr) begin
        wr_en   = (4'(lane) < width_r);
        wr_row  = lane_row(addr_r[AW-1:0], 2'(b));
        wr_byte = data_r[{lane, 3'b000} +: 8];
      end
    end

    always_ff @(posedge clk) begin
      if (wr_en) begin
        mem[wr_row] <= wr_byte;
      end
      if (cmd.accept) begin
        rd_byte_r <= mem[rd_row];
      end
    end

    assign rd_byte[b] = rd_byte_r;
  end

  logic [3:0][7:0] ld_byte;
  logic [63:0]     ld_val;
  logic            rd_ok, wr_ok;
  logic [7:0]      rd_en_ext, wr_en_ext;
  logic            res_reply_valid, res_fwd_rd, res_fwd_wr;
  logic [63:0]     res_reply_data, res_fwd_addr, res_fwd_data;
  logic [2:0]      res_fwd_bar;
  logic [3:0]      res_fwd_width;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ld_byte[i] = rd_byte[2'(i) + addr_r[1:0]];
    end
    case (width_r)
      4'd1:    ld_val = {56'd0, ld_byte[0]};
      4'd2:    ld_val = {48'd0, ld_byte[1], ld_byte[0]};
      default: ld_val = {32'd0, ld_byte};
    endcase
    rd_en_ext = {2'b00, bar_rd_en_r};
    wr_en_ext = {2'b00, bar_wr_en_r};
    rd_ok     = (size_of(bar_r) != '0) && rd_en_ext[bar_r];
    wr_ok     = (size_of(bar_r) != '0) && wr_en_ext[bar_r];

    res_reply_valid = 1'b0;
    res_reply_data  = '0;
    res_fwd_rd      = 1'b0;
    res_fwd_wr      = 1'b0;
    res_fwd_bar     = '0;
    res_fwd_addr    = '0;
    res_fwd_width   = '0;
    res_fwd_data    = '0;
    case (cmd_r)
      CMD_CFG_RD: begin
        res_reply_valid = 1'b1;
        res_reply_data  = (width_ok && fits) ? ld_val : ALL_ONES;
      end
      CMD_MEM_RD: begin
        res_reply_valid = 1'b1;
        res_reply_data  = ALL_ONES;
        if (rd_ok) begin
          res_reply_data = '0;
          res_fwd_rd     = 1'b1;
          res_fwd_bar    = bar_r;
          res_fwd_addr   = addr_r;
          res_fwd_width  = width_r;
        end
      end
      CMD_MEM_WR: begin
        if (wr_ok) begin
          res_fwd_wr    = 1'b1;
          res_fwd_bar   = bar_r;
          res_fwd_addr  = addr_r;
          res_fwd_width = width_r;
          res_fwd_data  = data_r;
        end
      end
      CMD_IO_RD: begin
        res_reply_valid = 1'b1;
        res_reply_data  = ALL_ONES;
      end
      default: begin
        res_reply_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_reply_valid     <= res_reply_valid;
      out_reply_data      <= res_reply_data;
      out_forward_read    <= res_fwd_rd;
      out_forward_write   <= res_fwd_wr;
      out_forward_bar     <= res_fwd_bar;
      out_forward_address <= res_fwd_addr;
      out_forward_width   <= res_fwd_width;
      out_forward_data    <= res_fwd_data;
    end
  end

endmodule

>>> sv/pcie_endpoint_config_space.sv
// Top level of the PCI endpoint configuration space and transaction decoder.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_stall   | cmd, address, bar_index, width, data
//   out     | output    | out_valid / out_stall | reply and forwarded access
//   cfg     | input     | cfg_wr_en             | cfg_index, cfg_wdata
//
// Each beat is registered while the four byte banks are read; the result is then
// formed and the banks written as the result register is loaded.
// A new beat is taken while the previous result waits, but it completes only once
// the result register is free, so a stalled output holds the block after one beat.
// After reset the store is filled with the header image, one dword row a cycle,
// up to the last of its (CONFIG_BYTES + 3) / 4 rows; configuration writes are taken meanwhile.
module pcie_endpoint_config_space import pecs_pkg::*; #(
  parameter int CONFIG_BYTES = 256,
  parameter int BAR_COUNT    = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [63:0] in_address,
  input  logic [2:0]  in_bar_index,
  input  logic [3:0]  in_access_width,
  input  logic [63:0] in_write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_reply_valid,
  output logic [63:0] out_reply_data,
  output logic        out_forward_read,
  output logic        out_forward_write,
  output logic [2:0]  out_forward_bar,
  output logic [63:0] out_forward_address,
  output logic [3:0]  out_forward_width,
  output logic [63:0] out_forward_data
);

  pecs_cmd_t cmd;
  pecs_sts_t sts;

  pecs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  pecs_datapath #(
    .CONFIG_BYTES (CONFIG_BYTES),
    .BAR_COUNT    (BAR_COUNT)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_cmd              (in_cmd),
    .in_address          (in_address),
    .in_bar_index        (in_bar_index),
    .in_access_width     (in_access_width),
    .in_write_data       (in_write_data),
    .out_reply_valid     (out_reply_valid),
    .out_reply_data      (out_reply_data),
    .out_forward_read    (out_forward_read),
    .out_forward_write   (out_forward_write),
    .out_forward_bar     (out_forward_bar),
    .out_forward_address (out_forward_address),
    .out_forward_width   (out_forward_width),
    .out_forward_data    (out_forward_data)
  );

endmodule

>>> sv/pecs_checker.sv
// Port checker for the configuration space block, with its bind.
module pecs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_reply_valid,
  input logic [63:0] out_reply_data,
  input logic        out_forward_read,
  input logic        out_forward_write
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_reply_data))
    else $error("stalled result beat changed or vanished");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again while a beat is in progress");

  a_fwd_read_reply: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_forward_read |-> out_reply_valid && (out_reply_data == 64'd0))
    else $error("forwarded read without an empty reply");

  a_fwd_write_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_forward_write |-> !out_reply_valid && !out_forward_read)
    else $error("forwarded write also carries a read");

endmodule

bind pcie_endpoint_config_space pecs_checker u_pecs_checker (.*);

>>> tb/tb_top.sv
// Self-checking testbench for the PCI endpoint configuration space and transaction decoder.
module tb_top;
  import pecs_pkg::*;

  localparam int CFG_BYTES = 256;
  localparam int BARS      = 6;
  localparam logic [2:0] CMD_RSVD_LO = 3'd6;
  localparam logic [2:0] CMD_RSVD_HI = 3'd7;

  typedef struct packed {
    logic        reply_valid;
    logic [63:0] reply_data;
    logic        fwd_read;
    logic        fwd_write;
    logic [2:0]  fwd_bar;
    logic [63:0] fwd_address;
    logic [3:0]  fwd_width;
    logic [63:0] fwd_data;
  } access_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_cmd = '0;
  logic [63:0] in_address = '0;
  logic [2:0]  in_bar_index = '0;
  logic [3:0]  in_access_width = '0;
  logic [63:0] in_write_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_reply_valid;
  logic [63:0] out_reply_data;
  logic        out_forward_read;
  logic        out_forward_write;
  logic [2:0]  out_forward_bar;
  logic [63:0] out_forward_address;
  logic [3:0]  out_forward_width;
  logic [63:0] out_forward_data;

  logic [7:0]  shadow_cfg [CFG_BYTES];
  logic [31:0] shadow_bar_size [BARS];
  logic [5:0]  shadow_rd_en = '0;
  logic [5:0]  shadow_wr_en = '0;
  logic [31:0] bar_plan [BARS];

  access_result_t expected_results [$];
  access_result_t head_result;
  int  errors = 0;
  bit  steady = 1'b0;

  pcie_endpoint_config_space dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_cmd              (in_cmd),
    .in_address          (in_address),
    .in_bar_index        (in_bar_index),
    .in_access_width     (in_access_width),
    .in_write_data       (in_write_data),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_reply_valid     (out_reply_valid),
    .out_reply_data      (out_reply_data),
    .out_forward_read    (out_forward_read),
    .out_forward_write   (out_forward_write),
    .out_forward_bar     (out_forward_bar),
    .out_forward_address (out_forward_address),
    .out_forward_width   (out_forward_width),
    .out_forward_data    (out_forward_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < CFG_BYTES; i++) shadow_cfg[i] = 8'h00;
    for (int b = 0; b < BARS; b++) shadow_bar_size[b] = 32'd0;
    shadow_cfg[8'h06] = 8'h10;
    shadow_cfg[8'h0A] = 8'h80;
    shadow_cfg[8'h0B] = 8'h11;
    shadow_cfg[8'h34] = 8'h40;
    shadow_cfg[8'h40] = 8'h05;
    shadow_cfg[8'h42] = 8'h01;
  end

  function automatic access_result_t predict_access(logic [2:0] cmd, logic [63:0] addr,
                                                    logic [2:0] bar, logic [3:0] width,
                                                    logic [63:0] data);
    access_result_t r;
    logic [31:0] size;
    logic [31:0] bar_word;
    logic [63:0] ibar;
    logic        ok_width;
    logic        fits;
    r = '0;
    ok_width = (width == 4'd1) || (width == 4'd2) || (width == 4'd4);
    fits = (addr < 64'(CFG_BYTES)) && ({60'd0, width} <= 64'(CFG_BYTES) - addr);
    size = (bar < BARS) ? shadow_bar_size[bar] : 32'd0;
    case (cmd)
      CMD_CFG_RD: begin
        r.reply_valid = 1'b1;
        r.reply_data = ALL_ONES;
        if (ok_width && fits) begin
          r.reply_data = '0;
          for (int i = 0; i < width; i++) r.reply_data[8*i +: 8] = shadow_cfg[addr[7:0] + i];
        end
      end
      CMD_CFG_WR: begin
        if (addr >= BAR_REG_FIRST && addr <= BAR_REG_LAST) begin
          ibar = (addr - BAR_REG_FIRST) >> 2;
          size = (ibar < BARS) ? shadow_bar_size[ibar[2:0]] : 32'd0;
          if (size != 32'd0) begin
            bar_word = data[31:0] & ~(size - 32'd1);
            for (int i = 0; i < 4; i++)
              shadow_cfg[BAR_REG_FIRST[7:0] + ibar[7:0] * 4 + i] = bar_word[8*i +: 8];
          end
        end else if (addr != ROM_REG && ok_width && fits) begin
          for (int i = 0; i < width; i++) shadow_cfg[addr[7:0] + i] = data[8*i +: 8];
        end
      end
      CMD_MEM_RD: begin
        r.reply_valid = 1'b1;
        r.reply_data = ALL_ONES;
        if (size != 32'd0 && shadow_rd_en[bar]) begin
          r.reply_data = '0;
          r.fwd_read = 1'b1;
          r.fwd_bar = bar;
          r.fwd_address = addr;
          r.fwd_width = width;
        end
      end
      CMD_MEM_WR: begin
        if (size != 32'd0 && shadow_wr_en[bar]) begin
          r.fwd_write = 1'b1;
          r.fwd_bar = bar;
          r.fwd_address = addr;
          r.fwd_width = width;
          r.fwd_data = data;
        end
      end
      CMD_IO_RD: begin
        r.reply_valid = 1'b1;
        r.reply_data = ALL_ONES;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result beat expected none actual reply %h", $time, out_reply_data);
      end else begin
        head_result = expected_results.pop_front();
        check_field("reply_valid", 64'(head_result.reply_valid), 64'(out_reply_valid));
        check_field("reply_data", head_result.reply_data, out_reply_data);
        check_field("forward_read", 64'(head_result.fwd_read), 64'(out_forward_read));
        check_field("forward_write", 64'(head_result.fwd_write), 64'(out_forward_write));
        check_field("forward_bar", 64'(head_result.fwd_bar), 64'(out_forward_bar));
        check_field("forward_address", head_result.fwd_address, out_forward_address);
        check_field("forward_width", 64'(head_result.fwd_width), 64'(out_forward_width));
        check_field("forward_data", head_result.fwd_data, out_forward_data);
      end
    end
    out_stall <= !steady && ($urandom_range(0, 99) < 30);
  end

  task automatic send_beat(logic [2:0] cmd, logic [63:0] addr, logic [2:0] bar,
                           logic [3:0] width, logic [63:0] data);
    int gap;
    gap = (!steady && $urandom_range(0, 99) < 30) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_cmd <= cmd;
    in_address <= addr;
    in_bar_index <= bar;
    in_access_width <= width;
    in_write_data <= data;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(predict_access(cmd, addr, bar, width, data));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    if (idx == CFG_BAR_RD_EN) shadow_rd_en = value[5:0];
    else if (idx == CFG_BAR_WR_EN) shadow_wr_en = value[5:0];
    else shadow_bar_size[idx - CFG_BAR0_SIZE] = value;
  endtask

  task automatic program_bars(logic [5:0] rd, logic [5:0] wr);
    logic [31:0] v;
    for (int b = 0; b < BARS; b++) write_reg(CFG_BAR0_SIZE + 3'(b), bar_plan[b]);
    v = $urandom;
    v[5:0] = rd;
    write_reg(CFG_BAR_RD_EN, v);
    v = $urandom;
    v[5:0] = wr;
    write_reg(CFG_BAR_WR_EN, v);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_settings();
    for (int b = 0; b < BARS; b++)
      bar_plan[b] = ($urandom_range(0, 3) == 0) ? 32'd0 : (32'd1 << $urandom_range(0, 31));
    program_bars(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
  endtask

  task automatic random_beat();
    logic [2:0]  cmd;
    logic [63:0] addr;
    logic [2:0]  bar;
    logic [3:0]  width;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 28) cmd = CMD_CFG_RD;
    else if (pick < 56) cmd = CMD_CFG_WR;
    else if (pick < 72) cmd = CMD_MEM_RD;
    else if (pick < 88) cmd = CMD_MEM_WR;
    else if (pick < 93) cmd = CMD_IO_RD;
    else if (pick < 97) cmd = CMD_IO_WR;
    else cmd = $urandom_range(0, 1) ? CMD_RSVD_HI : CMD_RSVD_LO;
    bar = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
    if (cmd == CMD_CFG_RD || cmd == CMD_CFG_WR) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) addr = 64'($urandom_range(0, 255));
      else if (pick < 70) addr = 64'($urandom_range(16, 39));
      else if (pick < 80) addr = 64'($urandom_range(248, 263));
      else addr = {$urandom, $urandom};
      width = ($urandom_range(0, 99) < 85) ? 4'(1 << $urandom_range(0, 2))
                                           : 4'($urandom_range(0, 15));
    end else begin
      addr = {$urandom, $urandom};
      width = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'(1 << $urandom_range(0, 3));
    end
    send_beat(cmd, addr, bar, width, {$urandom, $urandom});
  endtask

  task automatic test_reset_image();
    send_beat(CMD_CFG_RD, 64'h04, 3'd0, 4'd4, 64'd0);
    send_beat(CMD_CFG_RD, 64'h08, 3'd0, 4'd4, 64'd0);
    send_beat(CMD_CFG_RD, 64'h34, 3'd0, 4'd1, 64'd0);
    send_beat(CMD_CFG_RD, 64'h40, 3'd0, 4'd4, 64'd0);
    send_beat(CMD_CFG_RD, 64'hFD, 3'd0, 4'd4, 64'd0);
    send_beat(CMD_CFG_RD, ALL_ONES, 3'd0, 4'd1, 64'd0);
    send_beat(CMD_CFG_RD, 64'h00, 3'd0, 4'd3, 64'd0);
  endtask

  task automatic test_config_writes();
    wait_drained();
    bar_plan = '{32'd16, 32'd0, 32'd0, 32'd0, 32'd0, 32'h8000_0000};
    program_bars(6'b100001, 6'b100000);
    send_beat(CMD_CFG_WR, 64'h50, 3'd0, 4'd2, ALL_ONES);
    send_beat(CMD_CFG_WR, 64'h60, 3'd0, 4'd8, ALL_ONES);
    send_beat(CMD_CFG_WR, ROM_REG, 3'd0, 4'd4, ALL_ONES);
    send_beat(CMD_CFG_WR, 64'h13, 3'd0, 4'd1, ALL_ONES);
    send_beat(CMD_CFG_WR, BAR_REG_LAST, 3'd0, 4'd4, ALL_ONES);
    send_beat(CMD_CFG_WR, 64'h18, 3'd0, 4'd4, ALL_ONES);
    send_beat(CMD_CFG_RD, 64'h50, 3'd0, 4'd2, 64'd0);
    send_beat(CMD_CFG_RD, 64'h60, 3'd0, 4'd4, 64'd0);
    send_beat(CMD_CFG_RD, ROM_REG, 3'd0, 4'd4, 64'd0);
    send_beat(CMD_CFG_RD, BAR_REG_FIRST, 3'd0, 4'd4, 64'd0);
    send_beat(CMD_CFG_RD, 64'h18, 3'd0, 4'd4, 64'd0);
    send_beat(CMD_CFG_RD, BAR_REG_LAST, 3'd0, 4'd4, 64'd0);
  endtask

  task automatic test_memory_and_io();
    send_beat(CMD_MEM_RD, 64'h0123_4567_89AB_CDEF, 3'd0, 4'd8, 64'd0);
    send_beat(CMD_MEM_RD, 64'h10, 3'd1, 4'd4, 64'd0);
    send_beat(CMD_MEM_RD, 64'h10, 3'd7, 4'd4, 64'd0);
    send_beat(CMD_MEM_WR, ALL_ONES, 3'd5, 4'd4, ALL_ONES);
    send_beat(CMD_MEM_WR, 64'h20, 3'd0, 4'd2, 64'h5A5A);
    send_beat(CMD_IO_RD, 64'h40, 3'd0, 4'd4, 64'd0);
    send_beat(CMD_IO_WR, 64'h40, 3'd0, 4'd4, ALL_ONES);
    send_beat(CMD_RSVD_LO, ALL_ONES, 3'd7, 4'd15, ALL_ONES);
    send_beat(CMD_RSVD_HI, 64'd0, 3'd0, 4'd0, 64'd0);
  endtask

  task automatic test_unused_bars();
    wait_drained();
    bar_plan = '{default: 32'd0};
    program_bars(6'd0, 6'd0);
    repeat (100) random_beat();
  endtask

  task automatic test_extreme_bar_sizes();
    wait_drained();
    bar_plan = '{default: 32'h8000_0000};
    program_bars(6'h3F, 6'h3F);
    repeat (75) random_beat();
    wait_drained();
    bar_plan = '{default: 32'd1};
    program_bars(6'h3F, 6'h3F);
    repeat (75) random_beat();
  endtask

  task automatic test_back_to_back();
    wait_drained();
    random_settings();
    steady = 1'b1;
    repeat (150) random_beat();
    steady = 1'b0;
  endtask

  task automatic test_mixed_settings();
    repeat (2) begin
      wait_drained();
      random_settings();
      repeat (125) random_beat();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_image();
    test_config_writes();
    test_memory_and_io();
    test_unused_bars();
    test_extreme_bar_sizes();
    test_back_to_back();
    test_mixed_settings();
    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("pcie_endpoint_config_space test passed");
    end else begin
      $display("pcie_endpoint_config_space test failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("pcie_endpoint_config_space test failed");
    $finish;
  end

endmodule
